### rtl/http_response_header_parser_top_assert.svh
// ----------------------------------------------------------------------------
// HTTP response header parser - assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef HTTP_RESPONSE_HEADER_PARSER_TOP_ASSERT_SVH
`define HTTP_RESPONSE_HEADER_PARSER_TOP_ASSERT_SVH

// same-cycle implication
`define HRP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HRP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/hrp_pkg.sv
// ----------------------------------------------------------------------------
// hrp_pkg
// Types and constants of the HTTP response header parser.
// ----------------------------------------------------------------------------
package hrp_pkg;

    localparam int LINE_LIMIT_DEF  = 511;
    localparam int QUEUE_DEPTH_DEF = 4;

    typedef enum logic [2:0] {
        PH_STATUS,
        PH_NAME,
        PH_VALUE,
        PH_BODY,
        PH_BAD
    } t_phase;

    localparam logic [2:0] KIND_NAME    = 3'd0;
    localparam logic [2:0] KIND_VALUE   = 3'd1;
    localparam logic [2:0] KIND_BODY    = 3'd2;
    localparam logic [2:0] KIND_HDR_END = 3'd3;
    localparam logic [2:0] KIND_MSG_END = 3'd4;

    localparam logic [1:0] ST_COMPLETE = 2'd0;
    localparam logic [1:0] ST_UNTERM   = 2'd1;
    localparam logic [1:0] ST_BAD      = 2'd2;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] UPPER_A    = 8'h41;
    localparam logic [7:0] UPPER_Z    = 8'h5A;
    localparam logic [7:0] CASE_SHIFT = 8'h20;

    // "HTTP", element 0 first
    localparam logic [3:0][7:0] STATUS_PREFIX = {8'h50, 8'h54, 8'h54, 8'h48};

    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_message;
    } t_in_word;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] byte_out;
        logic [1:0] status;
        logic       run_last;
    } t_out_word;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] byte_out;
        logic [1:0] status;
    } t_res;

    // results of one input word, packed from slot 0
    typedef struct packed {
        logic [1:0]      cnt;
        t_res [2:0]      res;
    } t_bundle;

endpackage

### rtl/hrp_front.sv
// ----------------------------------------------------------------------------
// hrp_front
// Parser state machine: takes one byte a cycle while the queue accepts bundles, emits a bundle of results.
// ----------------------------------------------------------------------------
module hrp_front import hrp_pkg::*; #(
    parameter int LINE_LIMIT = LINE_LIMIT_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_word i_in_word,
    output logic     o_push_valid,
    input  logic     i_push_ready,
    output t_bundle  o_push_data
);

    localparam int LEN_W = $clog2(LINE_LIMIT + 1);

    typedef struct packed {
        t_phase           phase;
        logic [LEN_W-1:0] len;
        logic             skip;
    } t_lstate;

    typedef struct packed {
        t_lstate st;
        logic    emit;
        t_res    res;
    } t_lbres;

    function automatic t_lbres line_byte(input t_lstate s, input logic [7:0] b);
        t_lbres r;
        r      = '0;
        r.st   = s;
        if (s.len < LEN_W'(LINE_LIMIT)) begin
            case (s.phase)
                PH_STATUS: begin
                    if (s.len < LEN_W'(4) && b != STATUS_PREFIX[s.len[1:0]]) begin
                        r.st.phase = PH_BAD;
                        r.st.len   = '0;
                    end else begin
                        r.st.len = s.len + LEN_W'(1);
                    end
                end
                PH_NAME: begin
                    r.st.len = s.len + LEN_W'(1);
                    if (b == CHAR_COLON) begin
                        r.st.phase = PH_VALUE;
                        r.st.skip  = 1'b1;
                    end else begin
                        r.emit         = 1'b1;
                        r.res.kind     = KIND_NAME;
                        r.res.byte_out = (b >= UPPER_A && b <= UPPER_Z) ? b + CASE_SHIFT : b;
                    end
                end
                PH_VALUE: begin
                    r.st.len  = s.len + LEN_W'(1);
                    r.st.skip = 1'b0;
                    if (!(s.skip && b == CHAR_SPACE)) begin
                        r.emit         = 1'b1;
                        r.res.kind     = KIND_VALUE;
                        r.res.byte_out = b;
                    end
                end
                default: ;
            endcase
        end
        return r;
    endfunction

    function automatic t_lbres line_end(input t_lstate s);
        t_lbres r;
        r = '0;
        if (s.phase == PH_STATUS) begin
            r.st.phase = (s.len < LEN_W'(4)) ? PH_BAD : PH_NAME;
        end else if (s.len == '0) begin
            r.st.phase = PH_BODY;
        end else begin
            r.emit     = 1'b1;
            r.res.kind = KIND_HDR_END;
            r.st.phase = PH_NAME;
        end
        return r;
    endfunction

    function automatic logic in_line(input t_phase p);
        return p == PH_STATUS || p == PH_NAME || p == PH_VALUE;
    endfunction

    t_phase           r_phase, n_phase;
    logic [LEN_W-1:0] r_len, n_len;
    logic             r_skip, n_skip;
    logic             r_cr, n_cr;

    t_lstate s0, s1, s2;
    t_lbres  lb_cr, lb_end, lb_b;
    logic    v_a, v_b, v_c, consumed, accept;
    t_res    res_a, res_b, res_c;
    logic [1:0] cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_STATUS;
            r_len   <= '0;
            r_skip  <= 1'b0;
            r_cr    <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_skip  <= n_skip;
            r_cr    <= n_cr;
        end
    end

    always_comb begin
        accept   = i_in_valid && i_push_ready;
        s0       = '{phase: r_phase, len: r_len, skip: r_skip};
        lb_cr    = line_byte(s0, CHAR_CR);
        lb_end   = line_end(s0);
        v_a      = 1'b0;
        v_b      = 1'b0;
        res_a    = '0;
        res_b    = '0;
        consumed = 1'b0;
        s1       = s0;
        n_cr     = r_cr;

        if (r_phase == PH_BODY) begin
            v_a            = 1'b1;
            res_a.kind     = KIND_BODY;
            res_a.byte_out = i_in_word.byte_in;
        end else if (in_line(r_phase)) begin
            if (r_cr) begin
                n_cr = 1'b0;
                if (i_in_word.byte_in == CHAR_LF) begin
                    s1       = lb_end.st;
                    v_a      = lb_end.emit;
                    res_a    = lb_end.res;
                    consumed = 1'b1;
                end else begin
                    s1    = lb_cr.st;
                    v_a   = lb_cr.emit;
                    res_a = lb_cr.res;
                end
            end
        end else begin
            n_cr = 1'b0;
        end

        lb_b = line_byte(s1, i_in_word.byte_in);
        s2   = s1;
        if (in_line(r_phase) && !consumed && in_line(s1.phase)) begin
            if (i_in_word.byte_in == CHAR_CR && !i_in_word.end_of_message) begin
                n_cr = 1'b1;
            end else begin
                s2    = lb_b.st;
                v_b   = lb_b.emit;
                res_b = lb_b.res;
            end
        end

        v_c        = i_in_word.end_of_message;
        res_c      = '0;
        res_c.kind = KIND_MSG_END;
        if (s2.phase == PH_BODY) begin
            res_c.status = ST_COMPLETE;
        end else if (s2.phase == PH_NAME || s2.phase == PH_VALUE) begin
            res_c.status = ST_UNTERM;
        end else begin
            res_c.status = ST_BAD;
        end

        n_phase = r_phase;
        n_len   = r_len;
        n_skip  = r_skip;
        if (!accept) begin
            n_cr = r_cr;
        end else if (i_in_word.end_of_message) begin
            n_phase = PH_STATUS;
            n_len   = '0;
            n_skip  = 1'b0;
            n_cr    = 1'b0;
        end else begin
            n_phase = s2.phase;
            n_len   = s2.len;
            n_skip  = s2.skip;
        end

        cnt = 2'({1'b0, v_a} + {1'b0, v_b} + {1'b0, v_c});
        o_push_data.cnt    = cnt;
        o_push_data.res[0] = v_a ? res_a : (v_b ? res_b : res_c);
        o_push_data.res[1] = (v_a && v_b) ? res_b : res_c;
        o_push_data.res[2] = res_c;
        o_push_valid       = accept && (cnt != 2'd0);
        o_in_ready         = i_push_ready;
    end

endmodule

### rtl/hrp_fifo.sv
// ----------------------------------------------------------------------------
// hrp_fifo
// Short queue of result bundles between parser and serialiser.
// ----------------------------------------------------------------------------
module hrp_fifo import hrp_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push_valid,
    output logic    o_push_ready,
    input  t_bundle i_push_data,
    output logic    o_pop_valid,
    input  logic    i_pop,
    output t_bundle o_pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_bundle          r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             push, pop;

    always_comb begin
        o_push_ready = r_cnt != CNT_W'(DEPTH);
        o_pop_valid  = r_cnt != '0;
        o_pop_data   = r_mem[r_rd];
        push         = i_push_valid && o_push_ready;
        pop          = i_pop && o_pop_valid;
        n_wr         = r_wr;
        n_rd         = r_rd;
        n_cnt        = r_cnt;
        if (push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (push && !pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (pop && !push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

### rtl/hrp_back.sv
// ----------------------------------------------------------------------------
// hrp_back
// Serialiser: sends the results of each bundle one word a cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module hrp_back import hrp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_pop_valid,
    output logic      o_pop,
    input  t_bundle   i_pop_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    logic [1:0] r_idx, n_idx;
    logic       r_valid, n_valid;
    t_out_word  r_out, n_out;
    logic       load, last;
    t_res       sel;

    always_comb begin
        case (r_idx)
            2'd0:    sel = i_pop_data.res[0];
            2'd1:    sel = i_pop_data.res[1];
            default: sel = i_pop_data.res[2];
        endcase
        load    = i_pop_valid && (!r_valid || i_out_ready);
        last    = r_idx == i_pop_data.cnt - 2'd1;
        o_pop   = load && last;
        n_idx   = r_idx;
        n_valid = r_valid && !i_out_ready;
        n_out   = r_out;
        if (load) begin
            n_valid = 1'b1;
            n_out   = '{kind: sel.kind, byte_out: sel.byte_out,
                        status: sel.status, run_last: last};
            n_idx   = last ? 2'd0 : r_idx + 2'd1;
        end
        o_out_valid = r_valid;
        o_out_word  = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule

### rtl/http_response_header_parser_top.sv
// ----------------------------------------------------------------------------
// http_response_header_parser_top
// HTTP response header parser: byte stream in, classified result words out.
//
//   channel | handshake                | payload
//   in      | i_in_valid / o_in_ready   | i_in_word  (byte, end of message)
//   out     | o_out_valid / i_out_ready | o_out_word (kind, byte, status, last)
//
// One input byte a cycle while the bundle queue has room; the parser updates its state in that cycle.
// A byte giving k results (0 to 3) holds the serialiser for k output words;
// the bundle queue (QUEUE_DEPTH entries) absorbs short bursts.
// First result is offered once its bundle has passed the queue and the serialiser register.
// Synchronous active-low reset; either side may stall independently.
// ----------------------------------------------------------------------------
module http_response_header_parser_top import hrp_pkg::*; #(
    parameter int LINE_LIMIT  = LINE_LIMIT_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    logic    push_valid, push_ready, pop_valid, pop;
    t_bundle push_data, pop_data;

    hrp_front #(.LINE_LIMIT(LINE_LIMIT)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_word    (i_in_word),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_data  (push_data)
    );

    hrp_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop        (pop),
        .o_pop_data   (pop_data)
    );

    hrp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop       (pop),
        .i_pop_data  (pop_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule

### rtl/hrp_checker.sv
// ----------------------------------------------------------------------------
// hrp_checker
// Port-level checks of the HTTP response header parser.
// ----------------------------------------------------------------------------
`include "http_response_header_parser_top_assert.svh"

module hrp_checker import hrp_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_word  i_in_word,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_word o_out_word
);

    `HRP_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_out_word), "output word changed while stalled")
    `HRP_ASSERT_NOW(a_status_only_end, o_out_valid && o_out_word.kind != KIND_MSG_END,
        o_out_word.status == ST_COMPLETE, "status set on a non-end word")
    `HRP_ASSERT_NOW(a_marker_no_byte,
        o_out_valid && (o_out_word.kind == KIND_HDR_END || o_out_word.kind == KIND_MSG_END),
        o_out_word.byte_out == 8'h00, "marker word carries a byte")
    `HRP_ASSERT_NOW(a_end_is_last, o_out_valid && o_out_word.kind == KIND_MSG_END,
        o_out_word.run_last, "message end not last of its run")

endmodule

bind http_response_header_parser_top hrp_checker u_hrp_checker (.*);
